FILE: rtl/srm_pkg.sv
// Shared types, codes and field layout for the SCCB register master.
package srm_pkg;

  // Request codes carried in the input tuser
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [7:0] DEVICE_ADDR_RESET = 8'h42;
  localparam logic [7:0] READ_ADDR_BIT     = 8'h01;

  localparam int PHASE_W = 4;
  localparam int STEP_W  = 3;
  localparam int BITS_W  = 4;

  // Input tdata layout
  localparam int IN_DATA_W     = 24;
  localparam int IN_USER_W     = 2;
  localparam int IN_REG_LSB    = 0;
  localparam int IN_WDATA_LSB  = 8;
  localparam int IN_SAMPLE_BIT = 16;

  // Output tdata layout
  localparam int OUT_DATA_W     = 16;
  localparam int OUT_SCL_BIT    = 0;
  localparam int OUT_DRIVE_BIT  = 1;
  localparam int OUT_LEVEL_BIT  = 2;
  localparam int OUT_BUSY_BIT   = 3;
  localparam int OUT_DONE_BIT   = 4;
  localparam int OUT_NACK_BIT   = 5;
  localparam int OUT_RDATA_LSB  = 6;

  // Bus segments a transaction is built from
  typedef enum logic [3:0] {
    SEG_END,
    SEG_START,
    SEG_B_ADDR,
    SEG_B_REG,
    SEG_B_DATA,
    SEG_B_ADDR_RD,
    SEG_GAP,
    SEG_STOP,
    SEG_RBYTE,
    SEG_NOACK
  } seg_t;

  // Segment run at a given phase of a write or read transaction
  function automatic seg_t seg_lookup(input logic [PHASE_W-1:0] ph, input logic rd);
    seg_t s;
    s = SEG_END;
    case (ph)
      4'd1:    s = SEG_START;
      4'd2:    s = SEG_B_ADDR;
      4'd3:    s = SEG_GAP;
      4'd4:    s = SEG_B_REG;
      4'd5:    s = SEG_GAP;
      4'd6:    s = rd ? SEG_STOP : SEG_B_DATA;
      4'd7:    s = rd ? SEG_GAP : SEG_STOP;
      4'd8:    s = rd ? SEG_START : SEG_END;
      4'd9:    s = rd ? SEG_B_ADDR_RD : SEG_END;
      4'd10:   s = rd ? SEG_GAP : SEG_END;
      4'd11:   s = rd ? SEG_RBYTE : SEG_END;
      4'd12:   s = rd ? SEG_NOACK : SEG_END;
      4'd13:   s = rd ? SEG_STOP : SEG_END;
      default: s = SEG_END;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/sccb_register_master.sv
// SCCB register master: slot sequencer between an input register and a result register.
//
// Each input transfer is one bus time slot and yields one result transfer that gives
// the SCL level, SDA drive and level, busy, done, the write NACK flag and the last byte
// read. A write request (tuser 1) taken while idle runs start, device address, register,
// data and stop; a read request (tuser 2) runs the register phase, a stop and gap, then a
// restart, the read address, eight data bits, a no-acknowledge and a stop. One item is
// accepted every clock while the output side keeps taking results, since the slot logic
// is one short combinational step from the input register to the result register.
// device_addr is written through cfg_we/cfg_wdata only while no slot is in flight, a rule
// for the user that the block itself does not enforce; it resets to 0x42.
module sccb_register_master (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] reg_addr, [15:8] wr_data, [16] sda_sample, [23:17] zero
  input  logic [23:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] scl, [1] sda_drive, [2] sda_level, [3] busy_res, [4] done_res, [5] nack,
  // [13:6] rd_data, [15:14] zero
  output logic [15:0] m_axis_tdata
);

  // Input register
  logic       in_valid;
  logic [1:0] in_req;
  logic [7:0] in_reg_addr;
  logic [7:0] in_wr_data;
  logic       in_sample;
  logic       advance;

  // Sequencer state
  logic [7:0]                  device_addr;
  logic [srm_pkg::PHASE_W-1:0] phase, phase_next;
  logic [srm_pkg::STEP_W-1:0]  slot_step, slot_step_next;
  logic [srm_pkg::BITS_W-1:0]  bit_count, bit_count_next;
  logic [7:0]                  shift_reg, shift_reg_next;
  logic                        is_read, is_read_next;
  logic [7:0]                  saved_reg, saved_reg_next;
  logic [7:0]                  saved_data, saved_data_next;
  logic                        nack_flag, nack_flag_next;
  logic [7:0]                  read_byte, read_byte_next;
  logic                        scl_level, scl_level_next;
  logic                        sda_out_level, sda_out_level_next;

  // Slot results
  srm_pkg::seg_t seg;
  logic          fin;
  logic          o_scl;
  logic          o_drive;
  logic          o_busy;
  logic          o_done;
  logic [7:0]    byte_src;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  // Capture the slot transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_req      <= s_axis_tuser;
      in_reg_addr <= s_axis_tdata[srm_pkg::IN_REG_LSB +: 8];
      in_wr_data  <= s_axis_tdata[srm_pkg::IN_WDATA_LSB +: 8];
      in_sample   <= s_axis_tdata[srm_pkg::IN_SAMPLE_BIT];
    end
  end

  // Run one slot: latch a request, step the current segment, move to the next
  always_comb begin
    phase_next         = phase;
    slot_step_next     = slot_step;
    bit_count_next     = bit_count;
    shift_reg_next     = shift_reg;
    is_read_next       = is_read;
    saved_reg_next     = saved_reg;
    saved_data_next    = saved_data;
    nack_flag_next     = nack_flag;
    read_byte_next     = read_byte;
    scl_level_next     = scl_level;
    sda_out_level_next = sda_out_level;
    fin     = 1'b0;
    o_drive = 1'b1;
    o_busy  = 1'b0;
    o_done  = 1'b0;

    if (phase == '0 && (in_req == srm_pkg::REQ_WRITE || in_req == srm_pkg::REQ_READ)) begin
      is_read_next    = (in_req == srm_pkg::REQ_READ);
      saved_reg_next  = in_reg_addr;
      saved_data_next = in_wr_data;
      nack_flag_next  = 1'b0;
      phase_next      = srm_pkg::PHASE_W'(1);
      slot_step_next  = '0;
      bit_count_next  = '0;
    end

    seg = srm_pkg::seg_lookup(phase_next, is_read_next);

    // Pick the byte shifted out by a byte segment
    case (seg)
      srm_pkg::SEG_B_ADDR: byte_src = device_addr;
      srm_pkg::SEG_B_REG:  byte_src = saved_reg_next;
      srm_pkg::SEG_B_DATA: byte_src = saved_data_next;
      default:             byte_src = device_addr | srm_pkg::READ_ADDR_BIT;
    endcase

    // Levels during the slot
    unique case (seg)
      srm_pkg::SEG_END: ;
      srm_pkg::SEG_START: begin
        scl_level_next     = 1'b1;
        sda_out_level_next = (slot_step_next == '0);
        fin                = (slot_step_next != '0);
      end
      srm_pkg::SEG_STOP: begin
        if (slot_step_next == 3'd0) begin
          sda_out_level_next = 1'b0;
        end else if (slot_step_next == 3'd1) begin
          scl_level_next = 1'b1;
        end else begin
          sda_out_level_next = 1'b1;
          fin                = 1'b1;
        end
      end
      srm_pkg::SEG_NOACK: begin
        if (slot_step_next == 3'd1) begin
          sda_out_level_next = 1'b1;
          scl_level_next     = 1'b1;
        end else if (slot_step_next == 3'd2) begin
          scl_level_next = 1'b0;
        end else if (slot_step_next == 3'd3) begin
          sda_out_level_next = 1'b0;
          fin                = 1'b1;
        end
      end
      srm_pkg::SEG_GAP: begin
        fin = (slot_step_next != '0);
      end
      srm_pkg::SEG_RBYTE: begin
        o_drive = 1'b0;
        if (slot_step_next == '0) begin
          if (bit_count_next == '0) shift_reg_next = '0;
          scl_level_next = 1'b0;
        end else begin
          scl_level_next = 1'b1;
          shift_reg_next = {shift_reg_next[6:0], in_sample};
          if (bit_count_next >= 4'd7) begin
            read_byte_next = shift_reg_next;
            fin            = 1'b1;
          end
        end
      end
      srm_pkg::SEG_B_ADDR, srm_pkg::SEG_B_REG, srm_pkg::SEG_B_DATA,
      srm_pkg::SEG_B_ADDR_RD: begin
        if (!bit_count_next[3]) begin
          if (slot_step_next == '0) begin
            if (bit_count_next == '0) shift_reg_next = byte_src;
            sda_out_level_next = shift_reg_next[7];
            scl_level_next     = 1'b0;
          end else begin
            scl_level_next = 1'b1;
            shift_reg_next = {shift_reg_next[6:0], 1'b0};
          end
        end else begin
          o_drive = 1'b0;
          if (slot_step_next == '0) begin
            scl_level_next = 1'b0;
          end else begin
            scl_level_next = 1'b1;
            if (!is_read_next && in_sample) nack_flag_next = 1'b1;
            fin = 1'b1;
          end
        end
      end
      default: ;
    endcase

    o_scl = scl_level_next;

    // Trailing edges and slot counters
    unique case (seg)
      srm_pkg::SEG_END: ;
      srm_pkg::SEG_START: begin
        if (fin) scl_level_next = 1'b0;
        slot_step_next = slot_step_next + 3'd1;
      end
      srm_pkg::SEG_STOP, srm_pkg::SEG_NOACK, srm_pkg::SEG_GAP: begin
        slot_step_next = slot_step_next + 3'd1;
      end
      default: begin
        if (slot_step_next == '0) begin
          slot_step_next = 3'd1;
        end else begin
          scl_level_next = 1'b0;
          slot_step_next = '0;
          bit_count_next = bit_count_next + 4'd1;
        end
      end
    endcase

    // Advance to the next segment, or finish
    if (seg == srm_pkg::SEG_END) begin
      phase_next = '0;
    end else begin
      o_busy = 1'b1;
      if (fin) begin
        phase_next     = phase_next + 4'd1;
        slot_step_next = '0;
        bit_count_next = '0;
        if (srm_pkg::seg_lookup(phase_next, is_read_next) == srm_pkg::SEG_END) begin
          phase_next = '0;
          o_done     = 1'b1;
        end
      end
    end
  end

  // Hold the device address
  always_ff @(posedge clk) begin
    if (rst) begin
      device_addr <= srm_pkg::DEVICE_ADDR_RESET;
    end else if (cfg_we) begin
      device_addr <= cfg_wdata;
    end
  end

  // Commit the slot
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= '0;
      slot_step     <= '0;
      bit_count     <= '0;
      shift_reg     <= '0;
      is_read       <= 1'b0;
      saved_reg     <= '0;
      saved_data    <= '0;
      nack_flag     <= 1'b0;
      read_byte     <= '0;
      scl_level     <= 1'b1;
      sda_out_level <= 1'b1;
    end else if (in_valid && advance) begin
      phase         <= phase_next;
      slot_step     <= slot_step_next;
      bit_count     <= bit_count_next;
      shift_reg     <= shift_reg_next;
      is_read       <= is_read_next;
      saved_reg     <= saved_reg_next;
      saved_data    <= saved_data_next;
      nack_flag     <= nack_flag_next;
      read_byte     <= read_byte_next;
      scl_level     <= scl_level_next;
      sda_out_level <= sda_out_level_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid;
    end
    if (in_valid && advance) begin
      m_axis_tdata <= {2'b00, read_byte_next, nack_flag_next, o_done, o_busy,
                       sda_out_level_next, o_drive, o_scl};
    end
  end

endmodule

FILE: rtl/srm_checker.sv
// Port-level checks for the SCCB register master, bound to the top level.
module srm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // Input stalls only when a result waits at the output
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

  // A finishing slot belongs to a transaction
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[srm_pkg::OUT_DONE_BIT]
      |-> m_axis_tdata[srm_pkg::OUT_BUSY_BIT])
    else $error("done without busy");

  // SDA is released only inside a transaction
  a_release_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[srm_pkg::OUT_DRIVE_BIT]
      |-> m_axis_tdata[srm_pkg::OUT_BUSY_BIT])
    else $error("SDA released while idle");

  // A stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind sccb_register_master srm_checker u_srm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
